[rtl/ucw_pkg.sv]
// ucw_pkg: shared types, width codes and range tables for the column width block
// no dependencies; used by ucw_span_match and unicode_column_width_top

package ucw_pkg;

    localparam int CP_W          = 21;   // full code point width
    localparam int CODE_BITS_DEF = 21;   // default datapath width

    // column width codes, two's complement in three bits
    typedef logic signed [2:0] width_t;
    localparam width_t W_CTRL = 3'sb111;
    localparam width_t W_ZERO = 3'sb000;
    localparam width_t W_ONE  = 3'sb001;
    localparam width_t W_TWO  = 3'sb010;

    // control ranges
    localparam logic [CP_W-1:0] C0_END  = 21'h00020;
    localparam logic [CP_W-1:0] DEL_CP  = 21'h0007f;
    localparam logic [CP_W-1:0] C1_END  = 21'h000a0;
    localparam logic [CP_W-1:0] WIDE_GAP = 21'h0303f;

    // combining and format intervals
    localparam int ZERO_N   = 142;
    localparam int ZERO_GRP = 8;
    localparam int GRP_SIZE = (ZERO_N + ZERO_GRP - 1) / ZERO_GRP;
    localparam int HIT_W    = ZERO_GRP * GRP_SIZE;

    localparam logic [CP_W-1:0] ZERO_LO [0:ZERO_N-1] = '{
        21'h0300, 21'h0483, 21'h0488, 21'h0591, 21'h05BF, 21'h05C1, 21'h05C4, 21'h05C7,
        21'h0600, 21'h0610, 21'h064B, 21'h0670, 21'h06D6, 21'h06E7, 21'h06EA, 21'h070F,
        21'h0711, 21'h0730, 21'h07A6, 21'h07EB, 21'h0901, 21'h093C, 21'h0941, 21'h094D,
        21'h0951, 21'h0962, 21'h0981, 21'h09BC, 21'h09C1, 21'h09CD, 21'h09E2, 21'h0A01,
        21'h0A3C, 21'h0A41, 21'h0A47, 21'h0A4B, 21'h0A70, 21'h0A81, 21'h0ABC, 21'h0AC1,
        21'h0AC7, 21'h0ACD, 21'h0AE2, 21'h0B01, 21'h0B3C, 21'h0B3F, 21'h0B41, 21'h0B4D,
        21'h0B56, 21'h0B82, 21'h0BC0, 21'h0BCD, 21'h0C3E, 21'h0C46, 21'h0C4A, 21'h0C55,
        21'h0CBC, 21'h0CBF, 21'h0CC6, 21'h0CCC, 21'h0CE2, 21'h0D41, 21'h0D4D, 21'h0DCA,
        21'h0DD2, 21'h0DD6, 21'h0E31, 21'h0E34, 21'h0E47, 21'h0EB1, 21'h0EB4, 21'h0EBB,
        21'h0EC8, 21'h0F18, 21'h0F35, 21'h0F37, 21'h0F39, 21'h0F71, 21'h0F80, 21'h0F86,
        21'h0F90, 21'h0F99, 21'h0FC6, 21'h102D, 21'h1032, 21'h1036, 21'h1039, 21'h1058,
        21'h1160, 21'h135F, 21'h1712, 21'h1732, 21'h1752, 21'h1772, 21'h17B4, 21'h17B7,
        21'h17C6, 21'h17C9, 21'h17DD, 21'h180B, 21'h18A9, 21'h1920, 21'h1927, 21'h1932,
        21'h1939, 21'h1A17, 21'h1B00, 21'h1B34, 21'h1B36, 21'h1B3C, 21'h1B42, 21'h1B6B,
        21'h1DC0, 21'h1DFE, 21'h200B, 21'h202A, 21'h2060, 21'h206A, 21'h20D0, 21'h302A,
        21'h3099, 21'hA806, 21'hA80B, 21'hA825, 21'hFB1E, 21'hFE00, 21'hFE20, 21'hFEFF,
        21'hFFF9, 21'h10A01, 21'h10A05, 21'h10A0C, 21'h10A38, 21'h10A3F, 21'h1D167,
        21'h1D173, 21'h1D185, 21'h1D1AA, 21'h1D242, 21'hE0001, 21'hE0020, 21'hE0100
    };

    localparam logic [CP_W-1:0] ZERO_HI [0:ZERO_N-1] = '{
        21'h036F, 21'h0486, 21'h0489, 21'h05BD, 21'h05BF, 21'h05C2, 21'h05C5, 21'h05C7,
        21'h0603, 21'h0615, 21'h065E, 21'h0670, 21'h06E4, 21'h06E8, 21'h06ED, 21'h070F,
        21'h0711, 21'h074A, 21'h07B0, 21'h07F3, 21'h0902, 21'h093C, 21'h0948, 21'h094D,
        21'h0954, 21'h0963, 21'h0981, 21'h09BC, 21'h09C4, 21'h09CD, 21'h09E3, 21'h0A02,
        21'h0A3C, 21'h0A42, 21'h0A48, 21'h0A4D, 21'h0A71, 21'h0A82, 21'h0ABC, 21'h0AC5,
        21'h0AC8, 21'h0ACD, 21'h0AE3, 21'h0B01, 21'h0B3C, 21'h0B3F, 21'h0B43, 21'h0B4D,
        21'h0B56, 21'h0B82, 21'h0BC0, 21'h0BCD, 21'h0C40, 21'h0C48, 21'h0C4D, 21'h0C56,
        21'h0CBC, 21'h0CBF, 21'h0CC6, 21'h0CCD, 21'h0CE3, 21'h0D43, 21'h0D4D, 21'h0DCA,
        21'h0DD4, 21'h0DD6, 21'h0E31, 21'h0E3A, 21'h0E4E, 21'h0EB1, 21'h0EB9, 21'h0EBC,
        21'h0ECD, 21'h0F19, 21'h0F35, 21'h0F37, 21'h0F39, 21'h0F7E, 21'h0F84, 21'h0F87,
        21'h0F97, 21'h0FBC, 21'h0FC6, 21'h1030, 21'h1032, 21'h1037, 21'h1039, 21'h1059,
        21'h11FF, 21'h135F, 21'h1714, 21'h1734, 21'h1753, 21'h1773, 21'h17B5, 21'h17BD,
        21'h17C6, 21'h17D3, 21'h17DD, 21'h180D, 21'h18A9, 21'h1922, 21'h1928, 21'h1932,
        21'h193B, 21'h1A18, 21'h1B03, 21'h1B34, 21'h1B3A, 21'h1B3C, 21'h1B42, 21'h1B73,
        21'h1DCA, 21'h1DFF, 21'h200F, 21'h202E, 21'h2063, 21'h206F, 21'h20EF, 21'h302F,
        21'h309A, 21'hA806, 21'hA80B, 21'hA826, 21'hFB1E, 21'hFE0F, 21'hFE23, 21'hFEFF,
        21'hFFFB, 21'h10A03, 21'h10A06, 21'h10A0F, 21'h10A3A, 21'h10A3F, 21'h1D169,
        21'h1D182, 21'h1D18B, 21'h1D1AD, 21'h1D244, 21'hE0001, 21'hE007F, 21'hE01EF
    };

    // east asian wide and fullwidth intervals
    localparam int WIDE_N = 11;

    localparam logic [CP_W-1:0] WIDE_LO [0:WIDE_N-1] = '{
        21'h1100, 21'h2329, 21'h2E80, 21'hAC00, 21'hF900, 21'hFE10,
        21'hFE30, 21'hFF00, 21'hFFE0, 21'h20000, 21'h30000
    };

    localparam logic [CP_W-1:0] WIDE_HI [0:WIDE_N-1] = '{
        21'h115F, 21'h232A, 21'hA4CF, 21'hD7A3, 21'hFAFF, 21'hFE19,
        21'hFE6F, 21'hFF60, 21'hFFE6, 21'h2FFFD, 21'h3FFFD
    };

    // classification handed from the match stage to the select stage
    typedef struct packed {
        logic                nul;
        logic                ctrl;
        logic                wide;
        logic [ZERO_GRP-1:0] zero_grp;
    } class_t;

endpackage

[rtl/ucw_span_match.sv]
// ucw_span_match: registered range match of one code point against the constant tables
// depends on ucw_pkg

module ucw_span_match
    import ucw_pkg::*;
(
    input  logic            clk,
    input  logic [CP_W-1:0] code,
    output class_t          cls
);

    logic [HIT_W-1:0]    zero_hit;
    logic [WIDE_N-1:0]   wide_hit;
    class_t              cls_next;
    class_t              cls_reg;

    // one comparator pair per interval, padding bits stay low
    for (genvar i = 0; i < HIT_W; i++) begin : g_zero
        if (i < ZERO_N) begin : g_cmp
            assign zero_hit[i] = (code >= ZERO_LO[i]) && (code <= ZERO_HI[i]);
        end
        else begin : g_pad
            assign zero_hit[i] = 1'b0;
        end
    end

    for (genvar j = 0; j < WIDE_N; j++) begin : g_wide
        assign wide_hit[j] = (code >= WIDE_LO[j]) && (code <= WIDE_HI[j]);
    end

    // partial or per group, finished in the next stage
    for (genvar g = 0; g < ZERO_GRP; g++) begin : g_grp
        assign cls_next.zero_grp[g] = |zero_hit[g*GRP_SIZE +: GRP_SIZE];
    end

    assign cls_next.nul  = (code == '0);
    assign cls_next.ctrl = (code < C0_END) || ((code >= DEL_CP) && (code < C1_END));
    assign cls_next.wide = (|wide_hit) && (code != WIDE_GAP);

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
    end

    assign cls = cls_reg;

endmodule

[rtl/unicode_column_width_top.sv]
// unicode_column_width_top: terminal column width of one code point per cycle
// throughput: one request per cycle, busy is always low
// stages: input capture, interval match with partial ors, final or and select
// reset: rst_n clears the stage valid bits only, no clearing pass
// the receiver cannot stall, so done is a one-cycle strobe

module unicode_column_width_top
    import ucw_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CP_W-1:0]    code_point,
    output logic               done,
    output logic signed [2:0]  column_width
);

    // stage 1: capture and truncate to the datapath width
    logic            s1_valid_reg;
    logic [CP_W-1:0] s1_code_reg;
    logic [CP_W-1:0] s1_code_next;

    // stage 2: interval match, registered inside the match unit
    logic            s2_valid_reg;
    class_t          s2_cls;

    // stage 3: output register
    logic            done_reg;
    width_t          width_reg;
    width_t          width_next;

    // every request is independent, the pipe never backs up
    assign busy = 1'b0;

    // upper bits above the datapath width are ignored
    assign s1_code_next = CP_W'(code_point[CODE_BITS-1:0]);

    always_ff @(posedge clk)
    begin
        s1_code_reg <= s1_code_next;
    end

    ucw_span_match u_match
    (
        .clk  (clk),
        .code (s1_code_reg),
        .cls  (s2_cls)
    );

    // priority: nul, then controls, then combining, then wide
    always_comb
    begin
        if (s2_cls.nul)
        begin
            width_next = W_ZERO;
        end
        else if (s2_cls.ctrl)
        begin
            width_next = W_CTRL;
        end
        else if (|s2_cls.zero_grp)
        begin
            width_next = W_ZERO;
        end
        else if (s2_cls.wide)
        begin
            width_next = W_TWO;
        end
        else
        begin
            width_next = W_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    assign done         = done_reg;
    assign column_width = width_reg;

`ifndef SYNTH
    // only the four legal width codes leave the block
    a_width_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (column_width == W_CTRL || column_width == W_ZERO ||
                  column_width == W_ONE  || column_width == W_TWO))
        else $error("illegal column width code");

    // every accepted request yields a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("request lost in pipeline");

    // no result without a matching request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("result without request");

    // nul always measures zero columns
    a_nul_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(code_point[CODE_BITS-1:0], 3) == '0)) |-> (column_width == W_ZERO))
        else $error("nul not zero width");
`endif

endmodule

[tb/column_width_checker.sv]
// column_width_checker: watches the request and result channels of the column width block
// predicts the width of each accepted code point and compares results in order
// depends on ucw_pkg for the width type and code point width

module column_width_checker
    import ucw_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic [CP_W-1:0] code_point,
    input  logic            done,
    input  width_t          column_width,
    output int              failures,
    output int              outstanding
);

    // combining and format spans, as lo/hi pairs
    localparam int SPAN_PAIRS = 142;
    localparam int unsigned COMBINING [0:2*SPAN_PAIRS-1] = '{
        'h0300,'h036F, 'h0483,'h0486, 'h0488,'h0489, 'h0591,'h05BD,
        'h05BF,'h05BF, 'h05C1,'h05C2, 'h05C4,'h05C5, 'h05C7,'h05C7,
        'h0600,'h0603, 'h0610,'h0615, 'h064B,'h065E, 'h0670,'h0670,
        'h06D6,'h06E4, 'h06E7,'h06E8, 'h06EA,'h06ED, 'h070F,'h070F,
        'h0711,'h0711, 'h0730,'h074A, 'h07A6,'h07B0, 'h07EB,'h07F3,
        'h0901,'h0902, 'h093C,'h093C, 'h0941,'h0948, 'h094D,'h094D,
        'h0951,'h0954, 'h0962,'h0963, 'h0981,'h0981, 'h09BC,'h09BC,
        'h09C1,'h09C4, 'h09CD,'h09CD, 'h09E2,'h09E3, 'h0A01,'h0A02,
        'h0A3C,'h0A3C, 'h0A41,'h0A42, 'h0A47,'h0A48, 'h0A4B,'h0A4D,
        'h0A70,'h0A71, 'h0A81,'h0A82, 'h0ABC,'h0ABC, 'h0AC1,'h0AC5,
        'h0AC7,'h0AC8, 'h0ACD,'h0ACD, 'h0AE2,'h0AE3, 'h0B01,'h0B01,
        'h0B3C,'h0B3C, 'h0B3F,'h0B3F, 'h0B41,'h0B43, 'h0B4D,'h0B4D,
        'h0B56,'h0B56, 'h0B82,'h0B82, 'h0BC0,'h0BC0, 'h0BCD,'h0BCD,
        'h0C3E,'h0C40, 'h0C46,'h0C48, 'h0C4A,'h0C4D, 'h0C55,'h0C56,
        'h0CBC,'h0CBC, 'h0CBF,'h0CBF, 'h0CC6,'h0CC6, 'h0CCC,'h0CCD,
        'h0CE2,'h0CE3, 'h0D41,'h0D43, 'h0D4D,'h0D4D, 'h0DCA,'h0DCA,
        'h0DD2,'h0DD4, 'h0DD6,'h0DD6, 'h0E31,'h0E31, 'h0E34,'h0E3A,
        'h0E47,'h0E4E, 'h0EB1,'h0EB1, 'h0EB4,'h0EB9, 'h0EBB,'h0EBC,
        'h0EC8,'h0ECD, 'h0F18,'h0F19, 'h0F35,'h0F35, 'h0F37,'h0F37,
        'h0F39,'h0F39, 'h0F71,'h0F7E, 'h0F80,'h0F84, 'h0F86,'h0F87,
        'h0F90,'h0F97, 'h0F99,'h0FBC, 'h0FC6,'h0FC6, 'h102D,'h1030,
        'h1032,'h1032, 'h1036,'h1037, 'h1039,'h1039, 'h1058,'h1059,
        'h1160,'h11FF, 'h135F,'h135F, 'h1712,'h1714, 'h1732,'h1734,
        'h1752,'h1753, 'h1772,'h1773, 'h17B4,'h17B5, 'h17B7,'h17BD,
        'h17C6,'h17C6, 'h17C9,'h17D3, 'h17DD,'h17DD, 'h180B,'h180D,
        'h18A9,'h18A9, 'h1920,'h1922, 'h1927,'h1928, 'h1932,'h1932,
        'h1939,'h193B, 'h1A17,'h1A18, 'h1B00,'h1B03, 'h1B34,'h1B34,
        'h1B36,'h1B3A, 'h1B3C,'h1B3C, 'h1B42,'h1B42, 'h1B6B,'h1B73,
        'h1DC0,'h1DCA, 'h1DFE,'h1DFF, 'h200B,'h200F, 'h202A,'h202E,
        'h2060,'h2063, 'h206A,'h206F, 'h20D0,'h20EF, 'h302A,'h302F,
        'h3099,'h309A, 'hA806,'hA806, 'hA80B,'hA80B, 'hA825,'hA826,
        'hFB1E,'hFB1E, 'hFE00,'hFE0F, 'hFE20,'hFE23, 'hFEFF,'hFEFF,
        'hFFF9,'hFFFB, 'h10A01,'h10A03, 'h10A05,'h10A06, 'h10A0C,'h10A0F,
        'h10A38,'h10A3A, 'h10A3F,'h10A3F, 'h1D167,'h1D169, 'h1D173,'h1D182,
        'h1D185,'h1D18B, 'h1D1AA,'h1D1AD, 'h1D242,'h1D244, 'hE0001,'hE0001,
        'hE0020,'hE007F, 'hE0100,'hE01EF
    };

    typedef struct packed {
        logic [CP_W-1:0] cp;
        width_t          cols;
    } width_req_t;

    width_req_t width_queue [$];

    function automatic bit in_range(int unsigned c, int unsigned lo, int unsigned hi);
        return c >= lo && c <= hi;
    endfunction

    function automatic width_t measure_columns(logic [CP_W-1:0] raw);
        int unsigned c;
        bit combining;
        bit wide;
        c = int'(raw) & ((1 << CODE_BITS) - 1);
        combining = 1'b0;
        for (int i = 0; i < SPAN_PAIRS; i++)
            combining |= in_range(c, COMBINING[2*i], COMBINING[2*i+1]);
        wide = in_range(c, 'h1100, 'h115F) || c == 'h2329 || c == 'h232A ||
               (in_range(c, 'h2E80, 'hA4CF) && c != 'h303F) ||
               in_range(c, 'hAC00, 'hD7A3) || in_range(c, 'hF900, 'hFAFF) ||
               in_range(c, 'hFE10, 'hFE19) || in_range(c, 'hFE30, 'hFE6F) ||
               in_range(c, 'hFF00, 'hFF60) || in_range(c, 'hFFE0, 'hFFE6) ||
               in_range(c, 'h20000, 'h2FFFD) || in_range(c, 'h30000, 'h3FFFD);
        if (c == 0)
            return W_ZERO;
        if (c < 'h20 || (c >= 'h7F && c < 'hA0))
            return W_CTRL;
        if (combining)
            return W_ZERO;
        if (wide)
            return W_TWO;
        return W_ONE;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] column width mismatch: %s", $time, msg);
        failures++;
    endtask

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        width_req_t head;
        if (rst_n)
        begin
            if (start && !busy)
                width_queue.push_back('{cp: code_point, cols: measure_columns(code_point)});
            if (done !== 1'b0 && done !== 1'b1)
                report_mismatch("done strobe is unknown");
            else if (done)
            begin
                if (width_queue.size() == 0)
                    report_mismatch($sformatf("result %0d with no request waiting",
                                              column_width));
                else
                begin
                    head = width_queue.pop_front();
                    if (column_width !== head.cols)
                        report_mismatch($sformatf("cp %06h got %0d want %0d",
                                                  head.cp, column_width, head.cols));
                end
            end
            outstanding <= width_queue.size();
        end
    end

endmodule

[tb/testbench.sv]
// testbench: top level for the unicode column width block
// drives code point requests and gives the verdict from the checker's failure count
// depends on ucw_pkg, unicode_column_width_top and column_width_checker

module testbench;
    import ucw_pkg::*;

    // slowest correct run is about 1225 requests, so this limit is ample
    localparam int CYCLE_LIMIT = 60000;
    localparam int PHASE_REQS  = 300;

    // corners of the control, combining and wide classes, surrogates and values beyond unicode
    localparam logic [CP_W-1:0] DIRECTED [0:24] = '{
        21'h000000, 21'h000001, 21'h00001F, 21'h000020, 21'h00007E,
        21'h00007F, 21'h00009F, 21'h0000A0, 21'h000300, 21'h000370,
        21'h0010FF, 21'h001100, 21'h00115F, 21'h002329, 21'h00303F,
        21'h003040, 21'h00A4D0, 21'h00AC00, 21'h00D800, 21'h00FFFF,
        21'h02FFFE, 21'h03FFFD, 21'h10FFFF, 21'h110000, 21'h1FFFFF
    };

    logic            clk = 1'b0;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [CP_W-1:0] code_point;
    logic            done;
    width_t          column_width;

    int              failures;
    int              outstanding;
    int              cycle_count = 0;
    logic            took_req = 1'b0;

    unicode_column_width_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .code_point   (code_point),
        .done         (done),
        .column_width (column_width)
    );

    column_width_checker width_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .code_point   (code_point),
        .done         (done),
        .column_width (column_width),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // remembers whether the last rising edge took a request, read at the falling edge
    always @(posedge clk)
        took_req <= rst_n && start && !busy;

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // pick a code point near something interesting, or anywhere in 21 bits
    function automatic logic [CP_W-1:0] pick_code_point();
        int kind;
        int idx;
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        kind = $urandom_range(0, 9);
        if (kind == 3 || kind == 4)
        begin
            idx = $urandom_range(0, ZERO_N - 1);
            lo  = ZERO_LO[idx];
            hi  = ZERO_HI[idx];
        end
        else
        begin
            idx = $urandom_range(0, WIDE_N - 1);
            lo  = WIDE_LO[idx];
            hi  = WIDE_HI[idx];
        end
        case (kind)
            0, 1:    return CP_W'($urandom);
            2:       return CP_W'($urandom_range(0, 'hFF));
            3, 4, 5:
            begin
                // just outside, on the edges, or somewhere inside the span
                case ($urandom_range(0, 4))
                    0:       return lo - 1'b1;
                    1:       return lo;
                    2:       return lo + CP_W'($urandom % (hi - lo + 1));
                    3:       return hi;
                    default: return hi + 1'b1;
                endcase
            end
            6, 7:    return CP_W'($urandom_range(0, 'hFFFF));
            8:       return CP_W'($urandom_range('h10000, 'h3FFFF));
            default: return CP_W'($urandom_range('h110000, 'h1FFFFF));
        endcase
    endfunction

    // present one request at the falling edge and hold it until taken
    task automatic send_request(input logic [CP_W-1:0] cp);
        start      <= 1'b1;
        code_point <= cp;
        do
            @(negedge clk);
        while (!took_req);
    endtask

    // drop start and idle, with junk on the data port
    task automatic idle_for(input int cycles);
        start      <= 1'b0;
        code_point <= CP_W'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < idle_pct)
                idle_for($urandom_range(1, 3));
            send_request(pick_code_point());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        code_point = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners back to back
        foreach (DIRECTED[i])
            send_request(DIRECTED[i]);

        // hold off until the pipe is empty before the random part
        idle_for(1);
        wait_drained();

        // the receiver can never stall, so its phases reduce to sender behavior:
        // full rate, an idle gap before 68 of 100 requests, full rate again, then before 19 of 100
        run_phase(PHASE_REQS, 0);
        run_phase(PHASE_REQS, 68);
        idle_for(1);
        wait_drained();
        run_phase(PHASE_REQS, 0);
        run_phase(PHASE_REQS, 19);

        // let the last results come out, then wait on for stray strobes
        idle_for(1);
        wait_drained();
        repeat (6) @(negedge clk);

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
